// ===== sv/gamepad_input_conditioner_assert.svh =====
// Assertion macros for the gamepad input conditioner
`ifndef GAMEPAD_INPUT_CONDITIONER_ASSERT_SVH
`define GAMEPAD_INPUT_CONDITIONER_ASSERT_SVH
`ifndef ASSERT_OFF
`define GIC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("gamepad conditioner: same-cycle check failed");
`define GIC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("gamepad conditioner: next-cycle check failed");
`else
`define GIC_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define GIC_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== sv/gic_pkg.sv =====
// Shared widths, register indexes and constants of the gamepad input conditioner
`timescale 1ns / 1ps
`default_nettype none

package gic_pkg;
	localparam int BTN_W      = 8;
	localparam int STK_W      = 8;
	localparam int PORT_W     = 2;
	localparam int EN_W       = 4;
	localparam int DZ_W       = 16;
	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W  = 1;
	localparam int SUM_W      = 16;
	localparam int ROOT_W     = 16;
	localparam int QUO_W      = 16;
	localparam int OUT_W      = 16;
	localparam int MAG_W      = 15;
	// dividend is |c| << 22; the top part preloads the remainder
	localparam int DIV_PRE    = 22 - QUO_W;

	localparam logic [CFG_IDX_W-1:0] CFG_ENABLED_PORTS = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_DEADZONE_SQ   = CFG_IDX_W'(1);

	localparam logic [EN_W-1:0]  EN_RESET = '0;
	localparam logic [DZ_W-1:0]  DZ_RESET = DZ_W'(16);
	localparam logic [SUM_W-1:0] CLAMP_SQ = SUM_W'(4096);
	localparam logic [MAG_W-1:0] Q_ONE    = MAG_W'(16384);

	localparam int PORTS_DEF   = 4;
	localparam int BUTTONS_DEF = 8;
endpackage

`default_nettype wire

// ===== sv/gamepad_input_conditioner.sv =====
// Top level of the gamepad input conditioner: control, button edges, result register
// Usage:
// One sample enters on the in_* channel (valid/ready); a result leaves on the
// out_* channel (valid/ready). Registers are written through cfg_we, cfg_index and
// cfg_data: index 0 enables ports, index 1 sets the squared dead-zone radius. The
// user must write them only while no sample is in flight; this is not enforced.
// A sample for a disabled port is accepted and gives no result.
// An enabled sample runs through a bit-serial square sum, then, outside the dead
// zone, a two-bit-per-cycle square root, and, when the stick is clamped, two
// serial dividers in parallel. The next sample is taken in the cycle after the
// result enters the output register.
// The output register holds a result while out_ready is low; the next sample is
// already taken and computed, and waits in its last step until the register frees.
// Reset clears the button history of every port, disables all ports and sets the
// dead-zone radius squared to 16.
`timescale 1ns / 1ps
`default_nettype none
`include "gamepad_input_conditioner_assert.svh"

module gamepad_input_conditioner import gic_pkg::*; #(
	parameter int PORTS   = PORTS_DEF,
	parameter int BUTTONS = BUTTONS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [CFG_DATA_W-1:0]   cfg_data,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [PORT_W-1:0]       port,
	input  logic [BTN_W-1:0]        buttons_now,
	input  logic signed [STK_W-1:0] raw_x,
	input  logic signed [STK_W-1:0] raw_y,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [PORT_W-1:0]       out_port,
	output logic [BTN_W-1:0]        held,
	output logic [BTN_W-1:0]        pressed,
	output logic [BTN_W-1:0]        released,
	output logic signed [OUT_W-1:0] stick_x_out,
	output logic signed [OUT_W-1:0] stick_y_out,
	output logic [MAG_W-1:0]        magnitude
);
	localparam int PIDX_W = (PORTS > 1) ? $clog2(PORTS) : 1;
	localparam logic [BTN_W-1:0] BTN_MASK =
		(BUTTONS >= BTN_W) ? {BTN_W{1'b1}} : BTN_W'((1 << BUTTONS) - 1);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_SQ   = 3'd1;
	localparam logic [2:0] ST_ROOT = 3'd2;
	localparam logic [2:0] ST_DIV  = 3'd3;
	localparam logic [2:0] ST_OUT  = 3'd4;

	logic [2:0]                  state_q;
	logic [EN_W-1:0]             enabled_q;
	logic [DZ_W-1:0]             dz_q;
	logic [PORTS-1:0][BTN_W-1:0] last_q;
	logic                        out_valid_q;

	logic [PORT_W-1:0] port_q;
	logic [BTN_W-1:0]  held_q, pressed_q, released_q;
	logic [STK_W-1:0]  raw_x_q, raw_y_q, mag_x_q, mag_y_q;
	logic [OUT_W-1:0]  res_x_q, res_y_q;
	logic [MAG_W-1:0]  res_mag_q;

	logic [PORT_W-1:0] out_port_q;
	logic [BTN_W-1:0]  out_held_q, out_pressed_q, out_released_q;
	logic [OUT_W-1:0]  out_x_q, out_y_q;
	logic [MAG_W-1:0]  out_mag_q;

	logic              accept, port_ok, take, out_load;
	logic [PIDX_W-1:0] pidx;
	logic [BTN_W-1:0]  btn_now, btn_last;
	logic [STK_W-1:0]  abs_x, abs_y;
	logic              in_dz, clamp;
	logic              sq_done, rt_start, rt_done, dvx_done, dvy_done, dv_start;
	logic [SUM_W-1:0]  sq_sum;
	logic [ROOT_W-1:0] root;
	logic [QUO_W-1:0]  quo_x, quo_y;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid & in_ready;
	assign pidx     = PIDX_W'(port);
	assign port_ok  = (32'(port) < PORTS) && enabled_q[port];
	assign take     = accept & port_ok;
	assign btn_now  = buttons_now & BTN_MASK;
	assign btn_last = last_q[pidx];
	assign abs_x    = raw_x[STK_W-1] ? -raw_x : raw_x;
	assign abs_y    = raw_y[STK_W-1] ? -raw_y : raw_y;

	assign in_dz    = sq_sum < dz_q;
	assign clamp    = sq_sum > CLAMP_SQ;
	assign rt_start = (state_q == ST_SQ) && sq_done && !in_dz;
	assign dv_start = (state_q == ST_ROOT) && rt_done && clamp;
	assign out_load = (state_q == ST_OUT) && (!out_valid_q || out_ready);

	gic_sqsum u_sqsum (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (take),
		.mag_x  (abs_x),
		.mag_y  (abs_y),
		.done   (sq_done),
		.sum    (sq_sum)
	);

	gic_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (rt_start),
		.radicand (sq_sum),
		.done     (rt_done),
		.root     (root)
	);

	gic_div u_div_x (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (dv_start),
		.dividend_mag (mag_x_q),
		.divisor      (root),
		.done         (dvx_done),
		.quotient     (quo_x)
	);

	gic_div u_div_y (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (dv_start),
		.dividend_mag (mag_y_q),
		.divisor      (root),
		.done         (dvy_done),
		.quotient     (quo_y)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			enabled_q   <= EN_RESET;
			dz_q        <= DZ_RESET;
			last_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_ENABLED_PORTS: enabled_q <= cfg_data[EN_W-1:0];
					CFG_DEADZONE_SQ:   dz_q      <= cfg_data[DZ_W-1:0];
				endcase
			end
			if (take) begin
				last_q[pidx] <= btn_now;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: if (take) begin
					state_q <= ST_SQ;
				end
				ST_SQ: if (sq_done) begin
					state_q <= in_dz ? ST_OUT : ST_ROOT;
				end
				ST_ROOT: if (rt_done) begin
					state_q <= clamp ? ST_DIV : ST_OUT;
				end
				ST_DIV: if (dvx_done & dvy_done) begin
					state_q <= ST_OUT;
				end
				ST_OUT: if (out_load) begin
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			port_q     <= port;
			held_q     <= btn_now;
			pressed_q  <= btn_now & ~btn_last;
			released_q <= btn_last & ~btn_now;
			raw_x_q    <= raw_x;
			raw_y_q    <= raw_y;
			mag_x_q    <= abs_x;
			mag_y_q    <= abs_y;
		end
		if ((state_q == ST_SQ) && sq_done && in_dz) begin
			res_x_q   <= '0;
			res_y_q   <= '0;
			res_mag_q <= '0;
		end
		if ((state_q == ST_ROOT) && rt_done && !clamp) begin
			res_x_q   <= {raw_x_q, {(OUT_W-STK_W){1'b0}}};
			res_y_q   <= {raw_y_q, {(OUT_W-STK_W){1'b0}}};
			res_mag_q <= root[MAG_W-1:0];
		end
		if ((state_q == ST_DIV) && dvx_done && dvy_done) begin
			res_x_q   <= raw_x_q[STK_W-1] ? -quo_x : quo_x;
			res_y_q   <= raw_y_q[STK_W-1] ? -quo_y : quo_y;
			res_mag_q <= Q_ONE;
		end
		if (out_load) begin
			out_port_q     <= port_q;
			out_held_q     <= held_q;
			out_pressed_q  <= pressed_q;
			out_released_q <= released_q;
			out_x_q        <= res_x_q;
			out_y_q        <= res_y_q;
			out_mag_q      <= res_mag_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_port    = out_port_q;
	assign held        = out_held_q;
	assign pressed     = out_pressed_q;
	assign released    = out_released_q;
	assign stick_x_out = out_x_q;
	assign stick_y_out = out_y_q;
	assign magnitude   = out_mag_q;

	`GIC_ASSERT_IMP(a_mag_bound, clk, arst_n, out_valid_q, out_mag_q <= Q_ONE)
	`GIC_ASSERT_IMP(a_zero_stick, clk, arst_n, out_valid_q && out_mag_q == '0,
		out_x_q == '0 && out_y_q == '0)
	`GIC_ASSERT_IMP(a_btn_edges, clk, arst_n, out_valid_q,
		(out_pressed_q & out_released_q) == '0 && (out_pressed_q & ~out_held_q) == '0)
	`GIC_ASSERT_IMP(a_sq_in_state, clk, arst_n, sq_done, state_q == ST_SQ)
	`GIC_ASSERT_NXT(a_dz_skip, clk, arst_n, state_q == ST_SQ && sq_done && in_dz,
		state_q == ST_OUT)
endmodule

`default_nettype wire

// ===== sv/gic_sqsum.sv =====
// Bit-serial sum of squares of the two stick magnitudes
`timescale 1ns / 1ps
`default_nettype none

module gic_sqsum import gic_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [STK_W-1:0] mag_x,
	input  logic [STK_W-1:0] mag_y,
	output logic             done,
	output logic [SUM_W-1:0] sum
);
	localparam int CNT_W = $clog2(STK_W);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(STK_W - 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [SUM_W-1:0] mcand_x_q, mcand_y_q, acc_q;
	logic [STK_W-1:0] mplier_x_q, mplier_y_q;
	logic [SUM_W-1:0] part_x, part_y;

	assign part_x = mplier_x_q[0] ? mcand_x_q : '0;
	assign part_y = mplier_y_q[0] ? mcand_y_q : '0;
	assign done   = done_q;
	assign sum    = acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mcand_x_q  <= SUM_W'(mag_x);
			mcand_y_q  <= SUM_W'(mag_y);
			mplier_x_q <= mag_x;
			mplier_y_q <= mag_y;
			acc_q      <= '0;
		end else if (busy_q) begin
			acc_q      <= acc_q + part_x + part_y;
			mcand_x_q  <= mcand_x_q << 1;
			mcand_y_q  <= mcand_y_q << 1;
			mplier_x_q <= mplier_x_q >> 1;
			mplier_y_q <= mplier_y_q >> 1;
		end
	end
endmodule

`default_nettype wire

// ===== sv/gic_sqrt.sv =====
// Digit-by-digit square root of the sum of squares shifted up by sixteen
`timescale 1ns / 1ps
`default_nettype none

module gic_sqrt import gic_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [SUM_W-1:0]  radicand,
	output logic              done,
	output logic [ROOT_W-1:0] root
);
	localparam int REM_W = ROOT_W + 2;
	localparam int CNT_W = $clog2(ROOT_W);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(ROOT_W - 1);

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [SUM_W-1:0]  src_q;
	logic [REM_W-1:0]  rem_q;
	logic [ROOT_W-1:0] root_q;
	logic [REM_W-1:0]  rem_sh, trial;
	logic              fits;

	assign rem_sh = {rem_q[REM_W-3:0], src_q[SUM_W-1 -: 2]};
	assign trial  = {root_q, 2'b01};
	assign fits   = rem_sh >= trial;
	assign done   = done_q;
	assign root   = root_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			src_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			src_q <= src_q << 2;
			if (fits) begin
				rem_q  <= rem_sh - trial;
				root_q <= {root_q[ROOT_W-2:0], 1'b1};
			end else begin
				rem_q  <= rem_sh;
				root_q <= {root_q[ROOT_W-2:0], 1'b0};
			end
		end
	end
endmodule

`default_nettype wire

// ===== sv/gic_div.sv =====
// Restoring serial divider for the clamped stick components
`timescale 1ns / 1ps
`default_nettype none

module gic_div import gic_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [STK_W-1:0]  dividend_mag,
	input  logic [ROOT_W-1:0] divisor,
	output logic              done,
	output logic [QUO_W-1:0]  quotient
);
	localparam int CNT_W = $clog2(QUO_W);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(QUO_W - 1);

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [ROOT_W-1:0] rem_q, div_q;
	logic [QUO_W-1:0]  quo_q;
	logic [ROOT_W:0]   rem_sh, rem_sub;
	logic              fits;

	assign rem_sh   = {rem_q, 1'b0};
	assign rem_sub  = rem_sh - {1'b0, div_q};
	assign fits     = rem_sh >= {1'b0, div_q};
	assign done     = done_q;
	assign quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= ROOT_W'(dividend_mag) << DIV_PRE;
			div_q <= divisor;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? rem_sub[ROOT_W-1:0] : rem_sh[ROOT_W-1:0];
			quo_q <= {quo_q[QUO_W-2:0], fits};
		end
	end
endmodule

`default_nettype wire
